// ===== rtl/core/htc_pkg.sv =====
// Package for the hex text to CAN frame converter.
// Holds the scan phase type, default sizes and the character class functions.
// No dependencies.

package htc_pkg;

    // Default line layout.
    localparam int ID_CHARS_DEF   = 8;
    localparam int DATA_BYTES_DEF = 8;

    // Fixed field widths.
    localparam int ID_WIDTH   = 32;
    localparam int BYTE_WIDTH = 8;
    localparam int CHAR_WIDTH = 8;
    localparam int NIB_WIDTH  = 4;
    localparam int OUT_BYTES  = 8;

    // Phases of one hex field scan.
    typedef enum logic [1:0] {
        PHASE_SKIP   = 2'd0,
        PHASE_DIGITS = 2'd1,
        PHASE_STOP   = 2'd2
    } scan_phase_t;

    // Decoded character: hex flag and nibble value.
    typedef struct packed {
        logic                 is_hex;
        logic [NIB_WIDTH-1:0] nib;
    } hex_digit_t;

    // True for tab, line feed, vertical tab, form feed, carriage return and space.
    function automatic logic is_ws(input logic [CHAR_WIDTH-1:0] c);
        is_ws = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

    // Hex digit decode for 0-9, A-F and a-f.
    function automatic hex_digit_t hex_nibble(input logic [CHAR_WIDTH-1:0] c);
        hex_digit_t d;
        logic [CHAR_WIDTH-1:0] t;
        d = '0;
        t = '0;
        if ((c >= "0") && (c <= "9"))
        begin
            t = c - 8'("0");
            d.is_hex = 1'b1;
            d.nib = t[NIB_WIDTH-1:0];
        end
        else if ((c >= "A") && (c <= "F"))
        begin
            t = c - 8'("A") + 8'd10;
            d.is_hex = 1'b1;
            d.nib = t[NIB_WIDTH-1:0];
        end
        else if ((c >= "a") && (c <= "f"))
        begin
            t = c - 8'("a") + 8'd10;
            d.is_hex = 1'b1;
            d.nib = t[NIB_WIDTH-1:0];
        end
        hex_nibble = d;
    endfunction

endpackage

// ===== rtl/core/htc_scan.sv =====
// One step of a hex field scan: skip leading whitespace, take digits, then stop.
// Purely combinational. Depends on htc_pkg.

module htc_scan #(
    parameter int WIDTH = htc_pkg::BYTE_WIDTH
) (
    input  logic [htc_pkg::CHAR_WIDTH-1:0] character,
    input  htc_pkg::scan_phase_t           phase,
    input  logic [WIDTH-1:0]               value,
    output htc_pkg::scan_phase_t           phase_out,
    output logic [WIDTH-1:0]               value_out
);

    htc_pkg::hex_digit_t digit;

    assign digit = htc_pkg::hex_nibble(character);

    // Phase transition and nibble shift-in.
    always_comb
    begin
        phase_out = phase;
        value_out = value;
        case (phase)
            htc_pkg::PHASE_SKIP:
            begin
                if (!htc_pkg::is_ws(character))
                begin
                    if (digit.is_hex)
                    begin
                        value_out = WIDTH'(digit.nib);
                        phase_out = htc_pkg::PHASE_DIGITS;
                    end
                    else
                    begin
                        phase_out = htc_pkg::PHASE_STOP;
                    end
                end
            end
            htc_pkg::PHASE_DIGITS:
            begin
                if (digit.is_hex)
                begin
                    value_out = {value[WIDTH-htc_pkg::NIB_WIDTH-1:0], digit.nib};
                end
                else
                begin
                    phase_out = htc_pkg::PHASE_STOP;
                end
            end
            default:
            begin
                phase_out = phase;
            end
        endcase
    end

endmodule

// ===== rtl/core/hex_text_to_can_frame.sv =====
// Hex text to CAN frame converter: top level.
// A frame appears on the outputs in the cycle after its end-of-line character is taken.
// Throughput: one character per cycle while char_ready is high; the scan state updates in a single pass.
// A waiting frame stalls only the next end-of-line character, not ordinary ones.
// Reset (asynchronous, active low) clears the scan state and the frame valid flag.
// Depends on htc_pkg and htc_scan.

module hex_text_to_can_frame #(
    parameter int ID_CHARS   = htc_pkg::ID_CHARS_DEF,
    parameter int DATA_BYTES = htc_pkg::DATA_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              char_valid,
    output logic                              char_ready,
    input  logic [htc_pkg::CHAR_WIDTH-1:0]    character,
    input  logic                              end_of_line,
    output logic                              frame_valid,
    input  logic                              frame_ready,
    output logic [htc_pkg::ID_WIDTH-1:0]      frame_id,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte0,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte1,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte2,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte3,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte4,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte5,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte6,
    output logic [htc_pkg::BYTE_WIDTH-1:0]    byte7
);

    localparam int LAST_POS = ID_CHARS + 2 * DATA_BYTES;
    localparam int POS_W    = $clog2(LAST_POS + 1);
    localparam int IDX_W    = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam logic [POS_W-1:0] ID_POS   = POS_W'(ID_CHARS);
    localparam logic [POS_W-1:0] END_POS  = POS_W'(LAST_POS);
    localparam logic [POS_W-1:0] ID_LAST  = POS_W'(ID_CHARS - 1);

    localparam int BW = htc_pkg::BYTE_WIDTH;
    localparam int IW = htc_pkg::ID_WIDTH;

    // Scan state.
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  gap_reg, gap_next;
    logic [IW-1:0]         id_value_reg, id_value_next;
    htc_pkg::scan_phase_t  id_phase_reg, id_phase_next;
    htc_pkg::scan_phase_t  pair_phase_reg, pair_phase_next;
    logic [BW-1:0]         payload_reg [DATA_BYTES];
    logic [BW-1:0]         payload_next [DATA_BYTES];

    // Frame register.
    logic                  frame_valid_reg, frame_valid_next;
    logic [IW-1:0]         frame_id_reg;
    logic [BW-1:0]         frame_bytes_reg [htc_pkg::OUT_BYTES];

    // Values after this character, before the end-of-line clear.
    logic [POS_W-1:0]      pos_step;
    logic                  gap_step;
    logic [IW-1:0]         id_value_step;
    htc_pkg::scan_phase_t  id_phase_step;
    htc_pkg::scan_phase_t  pair_phase_step;
    logic [BW-1:0]         payload_step [DATA_BYTES];

    // Scanner operands.
    logic [POS_W-1:0]      pair_pos;
    logic [IDX_W-1:0]      pair_idx;
    htc_pkg::scan_phase_t  pair_phase_in;
    logic [BW-1:0]         pair_value_in;
    htc_pkg::scan_phase_t  id_phase_out;
    logic [IW-1:0]         id_value_out;
    htc_pkg::scan_phase_t  pair_phase_out;
    logic [BW-1:0]         pair_value_out;

    logic                  char_accept;
    logic                  frame_load;

    // An end-of-line request waits until the frame register is free.
    assign char_ready  = !end_of_line || !frame_valid_reg || frame_ready;
    assign char_accept = char_valid && char_ready;

    // Position within the payload and the byte it belongs to.
    assign pair_pos      = pos_reg - ID_POS;
    assign pair_idx      = pair_pos[IDX_W:1];
    assign pair_phase_in = pair_pos[0] ? pair_phase_reg : htc_pkg::PHASE_SKIP;
    assign pair_value_in = pair_pos[0] ? payload_reg[pair_idx] : '0;

    htc_scan #(
        .WIDTH (IW)
    ) u_id_scan (
        .character (character),
        .phase     (id_phase_reg),
        .value     (id_value_reg),
        .phase_out (id_phase_out),
        .value_out (id_value_out)
    );

    htc_scan #(
        .WIDTH (BW)
    ) u_pair_scan (
        .character (character),
        .phase     (pair_phase_in),
        .value     (pair_value_in),
        .phase_out (pair_phase_out),
        .value_out (pair_value_out)
    );

    // Advance the scan by one character.
    always_comb
    begin
        pos_step        = pos_reg;
        gap_step        = gap_reg;
        id_value_step   = id_value_reg;
        id_phase_step   = id_phase_reg;
        pair_phase_step = pair_phase_reg;
        payload_step    = payload_reg;
        if (pos_reg < ID_POS)
        begin
            id_value_step = id_value_out;
            id_phase_step = id_phase_out;
            pos_step      = pos_reg + POS_W'(1);
            if (pos_reg == ID_LAST)
            begin
                gap_step = 1'b1;
            end
        end
        else if (pos_reg < END_POS)
        begin
            if (!(gap_reg && htc_pkg::is_ws(character)))
            begin
                gap_step               = 1'b0;
                pair_phase_step        = pair_phase_out;
                payload_step[pair_idx] = pair_value_out;
                pos_step               = pos_reg + POS_W'(1);
            end
        end
    end

    // Commit the step, or clear everything at end of line.
    always_comb
    begin
        pos_next        = pos_reg;
        gap_next        = gap_reg;
        id_value_next   = id_value_reg;
        id_phase_next   = id_phase_reg;
        pair_phase_next = pair_phase_reg;
        payload_next    = payload_reg;
        if (char_accept)
        begin
            if (end_of_line)
            begin
                pos_next        = '0;
                gap_next        = 1'b0;
                id_value_next   = '0;
                id_phase_next   = htc_pkg::PHASE_SKIP;
                pair_phase_next = htc_pkg::PHASE_SKIP;
                for (int k = 0; k < DATA_BYTES; k++)
                begin
                    payload_next[k] = '0;
                end
            end
            else
            begin
                pos_next        = pos_step;
                gap_next        = gap_step;
                id_value_next   = id_value_step;
                id_phase_next   = id_phase_step;
                pair_phase_next = pair_phase_step;
                payload_next    = payload_step;
            end
        end
    end

    // A frame is produced only for a nonzero identifier.
    assign frame_load = char_accept && end_of_line && (id_value_step != '0);

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        if (frame_load)
        begin
            frame_valid_next = 1'b1;
        end
        else if (frame_ready)
        begin
            frame_valid_next = 1'b0;
        end
    end

    // Scan state and frame handshake registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            gap_reg         <= 1'b0;
            id_value_reg    <= '0;
            id_phase_reg    <= htc_pkg::PHASE_SKIP;
            pair_phase_reg  <= htc_pkg::PHASE_SKIP;
            frame_valid_reg <= 1'b0;
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                payload_reg[k] <= '0;
            end
        end
        else
        begin
            pos_reg         <= pos_next;
            gap_reg         <= gap_next;
            id_value_reg    <= id_value_next;
            id_phase_reg    <= id_phase_next;
            pair_phase_reg  <= pair_phase_next;
            frame_valid_reg <= frame_valid_next;
            payload_reg     <= payload_next;
        end
    end

    // Frame identifier register.
    always_ff @(posedge clk)
    begin
        if (frame_load)
        begin
            frame_id_reg <= id_value_step;
        end
    end

    // Bytes beyond the configured payload are loaded with zero for every frame.
    for (genvar g = 0; g < htc_pkg::OUT_BYTES; g++)
    begin : g_out_byte
        if (g < DATA_BYTES)
        begin : g_used
            always_ff @(posedge clk)
            begin
                if (frame_load)
                begin
                    frame_bytes_reg[g] <= payload_step[g];
                end
            end
        end
        else
        begin : g_unused
            always_ff @(posedge clk)
            begin
                if (frame_load)
                begin
                    frame_bytes_reg[g] <= '0;
                end
            end
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_id    = frame_id_reg;
    assign byte0       = frame_bytes_reg[0];
    assign byte1       = frame_bytes_reg[1];
    assign byte2       = frame_bytes_reg[2];
    assign byte3       = frame_bytes_reg[3];
    assign byte4       = frame_bytes_reg[4];
    assign byte5       = frame_bytes_reg[5];
    assign byte6       = frame_bytes_reg[6];
    assign byte7       = frame_bytes_reg[7];

endmodule

// ===== dv/hex_text_to_can_frame_tb.sv =====
// Self-checking testbench for hex_text_to_can_frame: text lines go in character by character.
// A line decoder in the bench or a typed frame predicts each frame, and a monitor checks every frame taken.
// Depends on htc_pkg and the hex_text_to_can_frame RTL.

module hex_text_to_can_frame_tb;

    localparam int ID_WIDTH      = htc_pkg::ID_WIDTH;
    localparam int BYTE_WIDTH    = htc_pkg::BYTE_WIDTH;
    localparam int CHAR_WIDTH    = htc_pkg::CHAR_WIDTH;
    localparam int NIB_WIDTH     = htc_pkg::NIB_WIDTH;
    localparam int OUT_BYTES     = htc_pkg::OUT_BYTES;
    localparam int ID_LEN        = htc_pkg::ID_CHARS_DEF;
    localparam int DATA_LEN      = htc_pkg::DATA_BYTES_DEF;
    localparam int NOT_HEX       = 16;
    localparam int RANDOM_CHARS  = 750;
    localparam int PRESSURE_HOLD = 400;
    localparam int DRAIN_CYCLES  = 8;

    // One decoded frame. data[k] holds byte k, so byte0 is the low byte of a typed constant.
    typedef struct packed {
        logic [ID_WIDTH-1:0]                   id;
        logic [OUT_BYTES-1:0][BYTE_WIDTH-1:0] data;
    } can_frame_t;

    // How a directed line is checked.
    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_FRAME,
        CHECK_NONE
    } line_check_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  char_valid;
    logic                  char_ready;
    logic [CHAR_WIDTH-1:0] character;
    logic                  end_of_line;
    logic                  frame_valid;
    logic                  frame_ready;
    logic [ID_WIDTH-1:0]   frame_id;
    logic [BYTE_WIDTH-1:0] byte0;
    logic [BYTE_WIDTH-1:0] byte1;
    logic [BYTE_WIDTH-1:0] byte2;
    logic [BYTE_WIDTH-1:0] byte3;
    logic [BYTE_WIDTH-1:0] byte4;
    logic [BYTE_WIDTH-1:0] byte5;
    logic [BYTE_WIDTH-1:0] byte6;
    logic [BYTE_WIDTH-1:0] byte7;

    // Line decoder state.
    int                    line_pos;
    bit                    in_gap;
    logic [ID_WIDTH-1:0]   id_acc;
    htc_pkg::scan_phase_t  id_phase;
    logic [BYTE_WIDTH-1:0] payload [OUT_BYTES];
    htc_pkg::scan_phase_t  pair_phase;

    can_frame_t            frames_due [$];
    string                 dir_text [$];
    line_check_t           dir_check [$];
    can_frame_t            dir_frame [$];
    logic [CHAR_WIDTH-1:0] line_chars [$];
    int                    mismatches = 0;
    bit                    no_gaps = 1'b0;
    bit                    pressure_go = 1'b0;
    bit                    pressure_done = 1'b0;

    hex_text_to_can_frame u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .character   (character),
        .end_of_line (end_of_line),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_id    (frame_id),
        .byte0       (byte0),
        .byte1       (byte1),
        .byte2       (byte2),
        .byte3       (byte3),
        .byte4       (byte4),
        .byte5       (byte5),
        .byte6       (byte6),
        .byte7       (byte7)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit is_blank(input logic [CHAR_WIDTH-1:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

    // Nibble value of a hex digit, NOT_HEX for anything else.
    function automatic int nibble_of(input logic [CHAR_WIDTH-1:0] c);
        if ((c >= "0") && (c <= "9"))
        begin
            return int'(c) - int'("0");
        end
        if ((c >= "A") && (c <= "F"))
        begin
            return int'(c) - int'("A") + 10;
        end
        if ((c >= "a") && (c <= "f"))
        begin
            return int'(c) - int'("a") + 10;
        end
        return NOT_HEX;
    endfunction

    // One step of a hex field scan: leading blanks, then digits, then stopped for good.
    task automatic scan_hex(input logic [CHAR_WIDTH-1:0] c, inout htc_pkg::scan_phase_t ph,
                            inout logic [ID_WIDTH-1:0] val);
        int nib;
        nib = nibble_of(c);
        case (ph)
            htc_pkg::PHASE_SKIP:
            begin
                if (!is_blank(c))
                begin
                    if (nib < NOT_HEX)
                    begin
                        val = ID_WIDTH'(nib);
                        ph  = htc_pkg::PHASE_DIGITS;
                    end
                    else
                    begin
                        ph = htc_pkg::PHASE_STOP;
                    end
                end
            end
            htc_pkg::PHASE_DIGITS:
            begin
                if (nib < NOT_HEX)
                begin
                    val = {val[ID_WIDTH-NIB_WIDTH-1:0], 4'(nib)};
                end
                else
                begin
                    ph = htc_pkg::PHASE_STOP;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic clear_decoder();
        line_pos   = 0;
        in_gap     = 1'b0;
        id_acc     = '0;
        id_phase   = htc_pkg::PHASE_SKIP;
        pair_phase = htc_pkg::PHASE_SKIP;
        for (int k = 0; k < OUT_BYTES; k++)
        begin
            payload[k] = '0;
        end
    endtask

    // Advance the line decoder by one character; at end of line return the frame, if any.
    task automatic decode_char(input logic [CHAR_WIDTH-1:0] c, input bit eol,
                               output bit emitted, output can_frame_t f);
        int p;
        logic [ID_WIDTH-1:0] v;
        emitted = 1'b0;
        f       = '0;
        if (line_pos < ID_LEN)
        begin
            scan_hex(c, id_phase, id_acc);
            line_pos++;
            if (line_pos == ID_LEN)
            begin
                in_gap = 1'b1;
            end
        end
        else if (line_pos < ID_LEN + 2 * DATA_LEN)
        begin
            // Blanks between identifier and payload do not take a position.
            if (!(in_gap && is_blank(c)))
            begin
                p      = line_pos - ID_LEN;
                v      = ID_WIDTH'(payload[p / 2]);
                in_gap = 1'b0;
                if (p % 2 == 0)
                begin
                    pair_phase = htc_pkg::PHASE_SKIP;
                    v          = '0;
                end
                scan_hex(c, pair_phase, v);
                payload[p / 2] = v[BYTE_WIDTH-1:0];
                line_pos++;
            end
        end
        if (eol)
        begin
            if (id_acc != '0)
            begin
                emitted = 1'b1;
                f.id    = id_acc;
                for (int k = 0; k < OUT_BYTES; k++)
                begin
                    f.data[k] = (k < DATA_LEN) ? payload[k] : '0;
                end
            end
            clear_decoder();
        end
    endtask

    // Mostly short idle gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    // Offer one character request, wait until it is taken, then record what it should produce.
    task automatic feed_char(input logic [CHAR_WIDTH-1:0] c, input bit eol,
                             input line_check_t chk, input can_frame_t typed);
        int n;
        bit emitted;
        can_frame_t f;
        n = no_gaps ? 0 : gap_len();
        if (n > 0)
        begin
            char_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        char_valid  <= 1'b1;
        character   <= c;
        end_of_line <= eol;
        @(posedge clk);
        while (!char_ready)
        begin
            @(posedge clk);
        end
        decode_char(c, eol, emitted, f);
        if (chk == CHECK_MODEL && emitted)
        begin
            frames_due.push_back(f);
        end
        else if (chk == CHECK_FRAME && eol)
        begin
            frames_due.push_back(typed);
        end
    endtask

    task automatic add_row(input string text, input line_check_t chk,
                           input logic [ID_WIDTH-1:0] id, input logic [63:0] data);
        can_frame_t f;
        f.id   = id;
        f.data = data;
        dir_text.push_back(text);
        dir_check.push_back(chk);
        dir_frame.push_back(f);
    endtask

    function automatic logic [CHAR_WIDTH-1:0] rand_hex();
        string digits;
        digits = "0123456789ABCDEFabcdef";
        return digits.getc($urandom_range(0, digits.len() - 1));
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] rand_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : CHAR_WIDTH'(9 + r);
    endfunction

    // Build one random line: mostly well formed, some truncated, zero identifier or noise.
    task automatic build_line();
        int kind;
        int lead;
        int ndig;
        int r;
        int cut;
        line_chars.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 30))
                line_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
            return;
        end
        // Identifier field: optional leading blanks, digits, then filler.
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        ndig = $urandom_range(1, ID_LEN - lead);
        for (int i = 0; i < ID_LEN; i++)
        begin
            if (i < lead)
            begin
                line_chars.push_back(rand_blank());
            end
            else if (i < lead + ndig)
            begin
                line_chars.push_back((kind == 8) ? CHAR_WIDTH'("0") : rand_hex());
            end
            else
            begin
                line_chars.push_back($urandom_range(0, 1) ? rand_blank()
                                                          : CHAR_WIDTH'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 4)) line_chars.push_back(rand_blank());
        end
        // Payload pairs.
        for (int k = 0; k < DATA_LEN; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                line_chars.push_back(rand_hex());
                line_chars.push_back(rand_hex());
            end
            else if (r == 7)
            begin
                line_chars.push_back(rand_blank());
                line_chars.push_back(rand_hex());
            end
            else if (r == 8)
            begin
                line_chars.push_back(rand_hex());
                line_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
            end
            else
            begin
                line_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
                line_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 5))
                line_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
        end
        if (kind == 7)
        begin
            cut = $urandom_range(1, line_chars.size());
            while (line_chars.size() > cut)
            begin
                void'(line_chars.pop_back());
            end
        end
    endtask

    // Compare a taken frame with the oldest one still due.
    task automatic check_frame();
        can_frame_t got;
        can_frame_t want;
        got.id   = frame_id;
        got.data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
        if (frames_due.size() == 0)
        begin
            report_mismatch($sformatf("frame id %08h with none due", frame_id));
            return;
        end
        want = frames_due.pop_front();
        if (got.id !== want.id)
        begin
            report_mismatch($sformatf("frame_id got %08h want %08h", got.id, want.id));
        end
        for (int k = 0; k < OUT_BYTES; k++)
        begin
            if (got.data[k] !== want.data[k])
            begin
                report_mismatch($sformatf("byte%0d got %02h want %02h (id %08h)",
                                          k, got.data[k], want.data[k], want.id));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && frame_valid && frame_ready)
        begin
            check_frame();
        end
    end

    // Frame receiver: random stalls, ready stretches, and one long hold-off under pressure.
    initial
    begin
        int stall_left;
        int steady_left;
        int r;
        stall_left  = 0;
        steady_left = 0;
        frame_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_go && !pressure_done)
            begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_HOLD;
            end
            if (stall_left > 0)
            begin
                frame_ready <= 1'b0;
                stall_left--;
            end
            else if (steady_left > 0)
            begin
                frame_ready <= 1'b1;
                steady_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    frame_ready <= 1'b1;
                end
                else if (r < 63)
                begin
                    steady_left = 60;
                    frame_ready <= 1'b1;
                end
                else
                begin
                    stall_left  = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                    frame_ready <= 1'b0;
                end
            end
        end
    end

    // Stimulus: directed lines first, then random lines.
    initial
    begin
        int sent;
        int len;
        rst_n       <= 1'b0;
        char_valid  <= 1'b0;
        character   <= '0;
        end_of_line <= 1'b0;
        clear_decoder();

        // Typed frames list byte7 first, byte0 last.
        add_row("123456780011223344556677\n", CHECK_FRAME, 32'h12345678,
                64'h77665544_33221100);
        add_row("FFFFFFFFFFFFFFFFFFFFFFFF", CHECK_FRAME, 32'hFFFFFFFF,
                64'hFFFFFFFF_FFFFFFFF);
        add_row("00000000AABBCCDDEEFF0011\n", CHECK_NONE, '0, '0);
        add_row("1", CHECK_FRAME, 32'h1, '0);
        add_row("zz", CHECK_NONE, '0, '0);
        add_row("\n", CHECK_NONE, '0, '0);
        add_row("DEADBEEF  5", CHECK_FRAME, 32'hDEADBEEF, 64'h05);
        add_row("00000001\t \t\n", CHECK_FRAME, 32'h1, '0);
        add_row("\377\200/:@G`g", CHECK_NONE, '0, '0);
        add_row("  abc     a1b2c3d4e5f60708 \n", CHECK_MODEL, '0, '0);
        add_row("\t\013\014\015 9AfG  1 2\t3x4", CHECK_MODEL, '0, '0);
        add_row("09afAF  0F9a/0:1@2G3`4g5trailing junk 12", CHECK_MODEL, '0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_text[row])
        begin
            len = dir_text[row].len();
            for (int i = 0; i < len; i++)
            begin
                feed_char(dir_text[row].getc(i), i == len - 1, dir_check[row],
                          dir_frame[row]);
            end
        end

        // Random lines; the receiver holds off once while lines keep coming.
        pressure_go = 1'b1;
        sent        = 0;
        while (sent < RANDOM_CHARS)
        begin
            build_line();
            no_gaps = ($urandom_range(0, 4) == 0);
            foreach (line_chars[i])
            begin
                feed_char(line_chars[i], i == line_chars.size() - 1, CHECK_MODEL, '0);
                sent++;
            end
        end
        char_valid <= 1'b0;

        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[hex_text_to_can_frame] OK");
        end
        else
        begin
            $display("[hex_text_to_can_frame] ERROR");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #5000000;
        $display("[hex_text_to_can_frame] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/htc_pkg.sv
rtl/core/htc_scan.sv
rtl/core/hex_text_to_can_frame.sv
dv/hex_text_to_can_frame_tb.sv
